[rtl/core/lcdgc_pkg.sv]
// Shared constants for the LCD custom glyph slot cache.
// No dependencies; imported by lcd_custom_glyph_slot_cache.
package lcdgc_pkg;

  localparam int SLOT_COUNT_DEF  = 8;
  localparam int LINE_LENGTH_DEF = 40;

  localparam int CP_W    = 21;
  localparam int ROWS_W  = 64;
  localparam int COL_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int BEAT_W  = 4;

  // codepoints below this go out as themselves
  localparam logic [CP_W-1:0]   CP_ASCII_LIMIT = 21'h00_0080;
  localparam logic [BYTE_W-1:0] CHAR_UNKNOWN   = 8'h3F;
  localparam logic [1:0]        CMD_CGRAM_TOP  = 2'b01;
  localparam logic              CMD_DDRAM_TOP  = 1'b1;
  localparam int                ROW_SHIFT      = 3;

  // beat positions within a slot load burst; beats 1..8 carry glyph rows
  localparam logic [BEAT_W-1:0] BEAT_CGRAM = 4'd0;
  localparam logic [BEAT_W-1:0] BEAT_DDRAM = 4'd9;
  localparam logic [BEAT_W-1:0] BEAT_SLOT  = 4'd10;

endpackage

[rtl/core/lcd_custom_glyph_slot_cache.sv]
// LCD custom glyph slot cache: turns codepoints into HD44780-style byte beats.
// Top level; depends on lcdgc_pkg.
//
// Usage: one input beat per character carries the codepoint, the glyph from
// the font store, the display line and the column. Each accepted beat yields
// one output beat (plain ASCII, cached slot hit, or '?' with no glyph) or an
// eleven-beat burst when a new slot is loaded: CGRAM address command, eight
// glyph rows shifted right by three, DDRAM re-address command, slot number.
// out_last marks the final beat of each character.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// An accepted character waits in the job register; each of its output beats is
// then registered in the output register before it is offered downstream.
// Throughput: one character per cycle for single-beat results while out_stall is
// low; a slot load keeps in_stall high until its last burst beat moves out.
// The slot lookup is one parallel compare against all slots at acceptance.
// Reset (rst_n low, synchronous) empties the job and output registers,
// clears every slot entry to zero and restarts round-robin at slot 0.
// A stalled receiver holds the output beat; in_stall is high while the pending
// job cannot pass its last beat into the output register.
module lcd_custom_glyph_slot_cache #(
  parameter int SLOT_COUNT  = lcdgc_pkg::SLOT_COUNT_DEF,
  parameter int LINE_LENGTH = lcdgc_pkg::LINE_LENGTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lcdgc_pkg::CP_W-1:0]   in_codepoint,
  input  logic                         in_glyph_found,
  input  logic [lcdgc_pkg::ROWS_W-1:0] in_glyph_rows,
  input  logic                         in_line_row,
  input  logic [lcdgc_pkg::COL_W-1:0]  in_column,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lcdgc_pkg::BYTE_W-1:0] out_lcd_byte,
  output logic                         out_command,
  output logic                         out_slot_loaded,
  output logic                         out_last
);
  import lcdgc_pkg::*;

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // slot table and round-robin pointer
  logic [CP_W-1:0]   slot_cp_r [SLOT_COUNT];
  logic [SLOT_W-1:0] next_slot_r;
  logic [SLOT_W-1:0] next_slot_nxt;

  // pending job
  logic              job_valid_r;
  logic              job_load_r;
  logic [BEAT_W-1:0] job_idx_r;
  logic [BYTE_W-1:0] job_byte_r;   // single byte, or DDRAM command on a load
  logic [SLOT_W-1:0] job_slot_r;
  logic [ROWS_W-1:0] job_rows_r;

  // output register
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_cmd_r;
  logic              out_loaded_r;
  logic              out_last_r;

  logic              in_accept;
  logic              out_free;
  logic              job_adv;
  logic              job_last;
  logic              job_done;

  logic              is_ascii;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic              do_load;
  logic [BYTE_W-1:0] single_byte;
  logic [COL_W-1:0]  col_sat;
  logic [BYTE_W-1:0] ddram_cmd;

  logic [BYTE_W-1:0] beat_byte;
  logic              beat_cmd;
  logic [2:0]        row_sel;
  logic [BYTE_W-1:0] row_raw;

  // ---------------------------------------------------------------- control
  assign out_free  = !out_valid_r || !out_stall;
  assign job_adv   = job_valid_r && out_free;
  assign job_last  = !job_load_r || (job_idx_r == BEAT_SLOT);
  assign job_done  = job_adv && job_last;
  assign in_stall  = job_valid_r && !job_done;
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------- lookup
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    // downward scan so the lowest matching slot wins
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (slot_cp_r[i] == in_codepoint) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(i);
      end
    end
  end

  assign is_ascii = (in_codepoint < CP_ASCII_LIMIT);
  assign do_load  = !is_ascii && !hit && in_glyph_found;

  always_comb begin
    priority if (is_ascii) begin
      single_byte = in_codepoint[BYTE_W-1:0];
    end else if (hit) begin
      single_byte = BYTE_W'(hit_idx);
    end else begin
      single_byte = CHAR_UNKNOWN;
    end
  end

  assign col_sat   = (in_column >= COL_W'(LINE_LENGTH)) ? COL_W'(LINE_LENGTH - 1) : in_column;
  assign ddram_cmd = {CMD_DDRAM_TOP, in_line_row, col_sat};

  assign next_slot_nxt = (next_slot_r == SLOT_W'(SLOT_COUNT - 1)) ? '0
                                                                  : next_slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_cp_r[i] <= '0;
      end
      next_slot_r <= '0;
    end else if (in_accept && do_load) begin
      slot_cp_r[next_slot_r] <= in_codepoint;
      next_slot_r            <= next_slot_nxt;
    end
  end

  // ---------------------------------------------------------------- job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
      job_load_r  <= 1'b0;
      job_idx_r   <= '0;
    end else if (in_accept) begin
      job_valid_r <= 1'b1;
      job_load_r  <= do_load;
      job_idx_r   <= BEAT_CGRAM;
    end else if (job_done) begin
      job_valid_r <= 1'b0;
    end else if (job_adv) begin
      job_idx_r <= job_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      job_byte_r <= do_load ? ddram_cmd : single_byte;
      job_slot_r <= next_slot_r;
      job_rows_r <= in_glyph_rows;
    end
  end

  // ---------------------------------------------------------------- beat select
  assign row_sel = 3'(job_idx_r - 1'b1);
  assign row_raw = job_rows_r[{row_sel, 3'b000} +: BYTE_W];

  always_comb begin
    priority if (!job_load_r) begin
      beat_byte = job_byte_r;
      beat_cmd  = 1'b0;
    end else if (job_idx_r == BEAT_CGRAM) begin
      beat_byte = {CMD_CGRAM_TOP, 3'(job_slot_r), 3'b000};
      beat_cmd  = 1'b1;
    end else if (job_idx_r == BEAT_DDRAM) begin
      beat_byte = job_byte_r;
      beat_cmd  = 1'b1;
    end else if (job_idx_r == BEAT_SLOT) begin
      beat_byte = BYTE_W'(job_slot_r);
      beat_cmd  = 1'b0;
    end else begin
      beat_byte = row_raw >> ROW_SHIFT;
      beat_cmd  = 1'b0;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (job_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_adv) begin
      out_byte_r   <= beat_byte;
      out_cmd_r    <= beat_cmd;
      out_loaded_r <= job_load_r;
      out_last_r   <= job_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lcd_byte    = out_byte_r;
  assign out_command     = out_cmd_r;
  assign out_slot_loaded = out_loaded_r;
  assign out_last        = out_last_r;

  // ---------------------------------------------------------------- checks
  a_stall_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> job_valid_r)
    else $error("input stalled with no pending job");

  a_burst_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_r && job_load_r) |-> (job_idx_r <= BEAT_SLOT))
    else $error("load burst beat index out of range");

  a_next_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(next_slot_r) < SLOT_COUNT))
    else $error("round-robin pointer beyond slot count");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_slot_loaded) |-> out_last)
    else $error("single-beat result not marked last");

endmodule
